// ===== rtl/core/utc_pkg.sv =====
`timescale 1ns / 1ps

package utc_pkg;

    localparam int GLYPH_COUNT = 256;

    localparam logic [15:0] REPLACEMENT_CP = 16'hFFFD;
    localparam logic [5:0]  HIGH_SUR_TAG   = 6'b110110;   // 0xD800..0xDBFF

    typedef enum logic [1:0] {
        ST_NORMAL   = 2'd0,
        ST_REPLACED = 2'd1,
        ST_TRUNC    = 2'd2
    } status_t;

    // Item handed from the accumulator stage to the resolve stage
    typedef struct packed {
        logic [31:0] acc;
        logic [2:0]  extra;
        logic        trunc;
        logic        last;
    } evt_t;

    localparam logic [15:0] CP437_TABLE [GLYPH_COUNT] = '{
        16'h0000, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
        16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
        16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
        16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
        16'h0040, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A, 16'h005B, 16'h005C, 16'h005D, 16'h005E, 16'h005F,
        16'h0060, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007A, 16'h007B, 16'h007C, 16'h007D, 16'h007E, 16'h007F,
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
        16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
        16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
        16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
        16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
        16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
    };

    // UTF-8 trailing-byte count of a lead byte, extended to four- and five-trailer leads
    function automatic logic [2:0] trailing_count(input logic [7:0] b);
        logic [2:0] n;
        begin
            case (b) inside
                [8'h00:8'hBF]: n = 3'd0;
                [8'hC0:8'hDF]: n = 3'd1;
                [8'hE0:8'hEF]: n = 3'd2;
                [8'hF0:8'hF7]: n = 3'd3;
                [8'hF8:8'hFB]: n = 3'd4;
                default:       n = 3'd5;
            endcase
            return n;
        end
    endfunction

    // Offset to remove once a sequence with the given trailing count is gathered
    function automatic logic [31:0] utf8_offset(input logic [2:0] extra);
        logic [31:0] off;
        begin
            case (extra)
                3'd1:    off = 32'h0000_3080;
                3'd2:    off = 32'h000E_2080;
                3'd3:    off = 32'h03C8_2080;
                3'd4:    off = 32'hFA08_2080;
                3'd5:    off = 32'h8208_2080;
                default: off = 32'h0000_0000;
            endcase
            return off;
        end
    endfunction

    // Reverse table lookup; the highest matching index wins, 0 when absent
    function automatic logic [7:0] glyph_of(input logic [15:0] cp);
        logic [7:0] g;
        begin
            g = 8'd0;
            for (int i = 0; i < GLYPH_COUNT; i++) begin
                if (CP437_TABLE[i] == cp) begin
                    g = i[7:0];
                end
            end
            return g;
        end
    endfunction

endpackage

// ===== rtl/core/utc_accum.sv =====
`timescale 1ns / 1ps

module utc_accum
    import utc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       evt_valid,
    input  logic       evt_take,
    output evt_t       evt
);

    logic [31:0] acc_reg,   acc_next;
    logic [2:0]  rem_reg,   rem_next;
    logic [2:0]  extra_reg, extra_next;
    logic        evt_valid_reg, evt_valid_next;
    logic        trunc_reg, trunc_next;
    logic        last_reg,  last_next;

    logic        accept;
    logic        lead;
    logic [2:0]  tc;
    logic [2:0]  rem_step;
    logic        done;

    // A held item leaves when the resolve stage loads it
    assign in_ready = !evt_valid_reg || evt_take;
    assign accept   = in_valid && in_ready;

    assign lead     = (rem_reg == 3'd0);
    assign tc       = trailing_count(in_byte);
    assign rem_step = lead ? tc : rem_reg - 3'd1;
    assign done     = (rem_step == 3'd0);

    always_comb
    begin
        acc_next       = acc_reg;
        rem_next       = rem_reg;
        extra_next     = extra_reg;
        evt_valid_next = evt_valid_reg;
        trunc_next     = trunc_reg;
        last_next      = last_reg;
        if (accept)
        begin
            acc_next       = lead ? {24'd0, in_byte}
                                  : {acc_reg[25:0], 6'd0} + {24'd0, in_byte};
            extra_next     = lead ? tc : extra_reg;
            // Drop an open sequence at the end of the string
            rem_next       = (done || in_last) ? 3'd0 : rem_step;
            evt_valid_next = done || in_last;
            trunc_next     = !done;
            last_next      = in_last;
        end
        else if (evt_take)
        begin
            evt_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg       <= 3'd0;
            extra_reg     <= 3'd0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            rem_reg       <= rem_next;
            extra_reg     <= extra_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        trunc_reg <= trunc_next;
        last_reg  <= last_next;
    end

    assign evt_valid = evt_valid_reg;
    assign evt.acc   = acc_reg;
    assign evt.extra = extra_reg;
    assign evt.trunc = trunc_reg;
    assign evt.last  = last_reg;

`ifndef SYNTH
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= 3'd5)
        else $error("trailing count out of range");

    a_rem_within_seq: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg != 3'd0 |-> (rem_reg <= extra_reg))
        else $error("remaining bytes exceed sequence length");

    a_trunc_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid_reg && trunc_reg |-> last_reg)
        else $error("truncated item not at end of string");

    a_open_seq_closed: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_last |=> rem_reg == 3'd0)
        else $error("sequence left open after last byte");
`endif

endmodule

// ===== rtl/core/utc_resolve.sv =====
`timescale 1ns / 1ps

module utc_resolve
    import utc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        evt_valid,
    output logic        evt_take,
    input  evt_t        evt,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_code_point,
    output logic [7:0]  out_glyph_index,
    output status_t     out_status,
    output logic        out_last
);

    logic        out_valid_reg, out_valid_next;
    logic [15:0] cp_reg, cp_next;
    logic [7:0]  glyph_reg, glyph_next;
    status_t     status_reg, status_next;
    logic        last_reg, last_next;

    logic        load;
    logic [31:0] ch;
    logic        replaced;
    logic [15:0] cp_sel;

    assign evt_take = !out_valid_reg || out_ready;
    assign load     = evt_valid && evt_take;

    assign ch       = evt.acc - utf8_offset(evt.extra);
    assign replaced = (|ch[31:16]) || (ch[15:10] == HIGH_SUR_TAG);
    assign cp_sel   = replaced ? REPLACEMENT_CP : ch[15:0];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        cp_next        = cp_reg;
        glyph_next     = glyph_reg;
        status_next    = status_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            last_next      = evt.last;
            if (evt.trunc)
            begin
                cp_next     = 16'd0;
                glyph_next  = 8'd0;
                status_next = ST_TRUNC;
            end
            else
            begin
                cp_next     = cp_sel;
                glyph_next  = glyph_of(cp_sel);
                status_next = replaced ? ST_REPLACED : ST_NORMAL;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg     <= cp_next;
        glyph_reg  <= glyph_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_code_point  = cp_reg;
    assign out_glyph_index = glyph_reg;
    assign out_status      = status_reg;
    assign out_last        = last_reg;

`ifndef SYNTH
    a_trunc_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_TRUNC |->
            cp_reg == 16'd0 && glyph_reg == 8'd0 && last_reg)
        else $error("truncated item carries data");

    a_replaced_cp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == ST_REPLACED |-> cp_reg == REPLACEMENT_CP)
        else $error("replaced item without replacement code point");
`endif

endmodule

// ===== rtl/core/utf8_to_cp437_glyph_decoder_top.sv =====
`timescale 1ns / 1ps

// Channel     Dir  tdata                              tuser        tlast
// s_axis      in   [7:0] text_byte                    -            last_byte
// m_axis      out  [15:0] code_point, [23:16] glyph   [1:0] status end_of_text
//
// One byte per cycle sustained while m_axis does not stall; the byte that completes
// a sequence is registered in the accumulator stage, then in the resolve/lookup stage.
// Bytes inside a multi-byte sequence produce no result unless the string ends there.
// rst_n clears the sequence state and both valid flags at once.
// A stall on m_axis holds the result register, then the held item in the
// accumulator stage, and only then drops s_axis_tready.

module utf8_to_cp437_glyph_decoder_top
    import utc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [15:0] code_point, [23:16] glyph_index
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);

    logic        evt_valid;
    logic        evt_take;
    evt_t        evt;
    logic [15:0] code_point;
    logic [7:0]  glyph_index;
    status_t     status;

    // Gather bytes of a sequence; hold a finished or truncated item
    utc_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_byte   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .evt_valid (evt_valid),
        .evt_take  (evt_take),
        .evt       (evt)
    );

    // Remove the offset, replace out-of-range values and high surrogates, look up the glyph
    utc_resolve u_resolve (
        .clk             (clk),
        .rst_n           (rst_n),
        .evt_valid       (evt_valid),
        .evt_take        (evt_take),
        .evt             (evt),
        .out_valid       (m_axis_tvalid),
        .out_ready       (m_axis_tready),
        .out_code_point  (code_point),
        .out_glyph_index (glyph_index),
        .out_status      (status),
        .out_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {glyph_index, code_point};
    assign m_axis_tuser = status;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import utc_pkg::*;

    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_PERCENT = 28;
    localparam int DRAIN_CYCLES = 8;      // pipeline is two deep; leave margin
    localparam int QUIET_LIMIT = 4000;    // cycles with no item moving on either side
    localparam int REPORT_LIMIT = 10;
    localparam int SINK_HOLD_CYCLES = 150;

    // One predicted result: code point, glyph, status, end-of-text flag
    typedef struct packed {
        logic [15:0] cp;
        logic [7:0]  glyph;
        status_t     status;
        logic        eot;
    } glyph_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] text_byte
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // [15:0] code_point, [23:16] glyph_index
    logic [1:0]  m_axis_tuser;            // [1:0] status
    logic        m_axis_tlast;

    // Predictor state: gathered value, trailing bytes still due, trailing count of the sequence
    logic [31:0] gather_acc = '0;
    logic [2:0]  gather_left = '0;
    logic [2:0]  gather_len = '0;

    glyph_result_t pending_glyphs[$];
    glyph_result_t sink_want;

    int bytes_sent = 0;
    int glyphs_checked = 0;
    int replaced_seen = 0;
    int truncated_seen = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;
    int sink_hold_req = 0;
    int sink_hold_left = 0;
    bit src_idle_on = 1'b1;
    bit sink_idle_on = 1'b1;

    utf8_to_cp437_glyph_decoder_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #HALF_PERIOD clk = ~clk;

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Trailing-byte count that a lead byte announces
    function automatic logic [2:0] lead_trailers(input logic [7:0] b);
        if (b < 8'hC0) return 3'd0;
        if (b < 8'hE0) return 3'd1;
        if (b < 8'hF0) return 3'd2;
        if (b < 8'hF8) return 3'd3;
        if (b < 8'hFC) return 3'd4;
        return 3'd5;
    endfunction

    // Sum of the marker bits of a sequence of the given trailing count
    function automatic logic [31:0] seq_offset(input logic [2:0] n);
        case (n)
            3'd1:    return 32'h0000_3080;
            3'd2:    return 32'h000E_2080;
            3'd3:    return 32'h03C8_2080;
            3'd4:    return 32'hFA08_2080;
            3'd5:    return 32'h8208_2080;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // Reverse lookup; a later table entry overrides an earlier one
    function automatic logic [7:0] glyph_lookup(input logic [15:0] cp);
        logic [7:0] idx;
        idx = 8'd0;
        for (int i = 0; i < GLYPH_COUNT; i++) begin
            if (CP437_TABLE[i] == cp) idx = 8'(i);
        end
        return idx;
    endfunction

    // Advance the predictor by one accepted byte; 1 when a result is due
    function automatic bit predict_glyph(input logic [7:0] b, input logic lst,
                                         output glyph_result_t r);
        logic [31:0] cp_wide;
        r = '0;
        if (gather_left == 3'd0) begin
            gather_len = lead_trailers(b);
            gather_left = gather_len;
            gather_acc = {24'd0, b};
        end
        else begin
            gather_acc = (gather_acc << 6) + {24'd0, b};
            gather_left = gather_left - 3'd1;
        end
        if (gather_left != 3'd0) begin
            if (!lst) return 1'b0;
            // String ends inside a sequence: drop it, report the cut
            gather_acc = '0;
            gather_left = '0;
            gather_len = '0;
            r.status = ST_TRUNC;
            r.eot = 1'b1;
            return 1'b1;
        end
        cp_wide = gather_acc - seq_offset(gather_len);
        if (cp_wide > 32'h0000_FFFF
            || (cp_wide >= 32'h0000_D800 && cp_wide <= 32'h0000_DBFF)) begin
            r.cp = REPLACEMENT_CP;
            r.status = ST_REPLACED;
        end
        else begin
            r.cp = cp_wide[15:0];
            r.status = ST_NORMAL;
        end
        r.glyph = glyph_lookup(r.cp);
        r.eot = lst;
        gather_acc = '0;
        gather_len = '0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // Source side
    // ---------------------------------------------------------------------

    // Offer one byte, hold it until taken, then predict what it causes.
    // Valid is not dropped here, so back-to-back bytes keep it high.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        glyph_result_t r;
        while (src_idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'($urandom);
            s_axis_tlast <= 1'($urandom);
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= lst;
        do @(posedge clk); while (!s_axis_tready);
        bytes_sent++;
        if (predict_glyph(b, lst, r)) pending_glyphs = {pending_glyphs, r};
    endtask

    task automatic send_bytes(input logic [7:0] seq[$], input logic close);
        foreach (seq[i]) send_byte(seq[i], close && (i == seq.size() - 1));
    endtask

    // Drop valid and hold until every predicted result is back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_glyphs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic void utf8_encode(input logic [31:0] cp, output logic [7:0] q[$]);
        q = {};
        if (cp < 32'h80) begin
            q = {q, cp[7:0]};
        end
        else if (cp < 32'h800) begin
            q = {q, {3'b110, cp[10:6]}};
            q = {q, {2'b10, cp[5:0]}};
        end
        else if (cp < 32'h10000) begin
            q = {q, {4'b1110, cp[15:12]}};
            q = {q, {2'b10, cp[11:6]}};
            q = {q, {2'b10, cp[5:0]}};
        end
        else begin
            q = {q, {5'b11110, cp[20:18]}};
            q = {q, {2'b10, cp[17:12]}};
            q = {q, {2'b10, cp[11:6]}};
            q = {q, {2'b10, cp[5:0]}};
        end
    endfunction

    // One complete sequence: mostly well-formed text, some noise, some cut off
    task automatic send_random_sequence();
        logic [7:0] seq[$];
        logic [7:0] lead;
        logic [2:0] trail;
        int kind;
        bit close;
        kind = $urandom_range(99);
        close = ($urandom_range(99) < 8);
        if (kind < 22) begin
            utf8_encode($urandom_range(8'h7F), seq);
        end
        else if (kind < 40) begin
            utf8_encode({16'd0, CP437_TABLE[$urandom_range(GLYPH_COUNT - 1)]}, seq);
        end
        else if (kind < 53) begin
            utf8_encode($urandom_range(32'h7FF, 32'h80), seq);
        end
        else if (kind < 66) begin
            utf8_encode($urandom_range(32'hFFFF, 32'h800), seq);
        end
        else if (kind < 72) begin
            utf8_encode($urandom_range(32'hDFFF, 32'hD800), seq);
        end
        else if (kind < 80) begin
            utf8_encode($urandom_range(32'h1F_FFFF, 32'h1_0000), seq);
        end
        else if (kind < 91) begin
            // Noise: any lead, often a five- or four-trailer one, loose trailing bytes
            lead = ($urandom_range(1) != 0) ? 8'($urandom_range(8'hFF, 8'hF8))
                                             : 8'($urandom);
            seq = {seq, lead};
            trail = lead_trailers(lead);
            repeat (trail) begin
                if ($urandom_range(99) < 70) seq = {seq, {2'b10, 6'($urandom)}};
                else seq = {seq, 8'($urandom)};
            end
        end
        else begin
            // Cut a multi-byte sequence short and end the string there
            utf8_encode($urandom_range(32'h1F_FFFF, 32'h80), seq);
            repeat ($urandom_range(seq.size() - 1, 1)) void'(seq.pop_back());
            close = 1'b1;
        end
        send_bytes(seq, close);
    endtask

    task automatic send_random_bytes(input int n);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n) send_random_sequence();
    endtask

    // ---------------------------------------------------------------------
    // Sink side: check every result, drive ready with idling and long holds
    // ---------------------------------------------------------------------

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_glyphs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: cp %h glyph %h status %0d eot %b",
                             m_axis_tdata[15:0], m_axis_tdata[23:16], m_axis_tuser,
                             m_axis_tlast);
            end
            else begin
                sink_want = pending_glyphs.pop_front();
                glyphs_checked++;
                if (sink_want.status == ST_REPLACED) replaced_seen++;
                if (sink_want.status == ST_TRUNC) truncated_seen++;
                if (m_axis_tdata[15:0] !== sink_want.cp
                    || m_axis_tdata[23:16] !== sink_want.glyph
                    || m_axis_tuser !== sink_want.status
                    || m_axis_tlast !== sink_want.eot) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"mismatch: expected cp %h glyph %h status %0d eot %b,",
                                  " got cp %h glyph %h status %0d eot %b"},
                                 sink_want.cp, sink_want.glyph, sink_want.status,
                                 sink_want.eot, m_axis_tdata[15:0], m_axis_tdata[23:16],
                                 m_axis_tuser, m_axis_tlast);
                end
            end
        end
        if (sink_hold_req > 0) begin
            sink_hold_left = sink_hold_req;
            sink_hold_req = 0;
        end
        if (sink_hold_left > 0) begin
            sink_hold_left--;
            m_axis_tready <= 1'b0;
        end
        else begin
            m_axis_tready <= !(sink_idle_on && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Watchdog: too long with nothing moving on either side ends the run
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Field extremes and each special case of the decode
    task automatic test_directed();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_bytes('{8'hC2, 8'hA0}, 1'b0);                // no-break space, last glyph
        send_bytes('{8'hE2, 8'h98, 8'hBA}, 1'b0);         // smiley, glyph 1
        send_bytes('{8'hED, 8'hA0, 8'h80}, 1'b0);         // high surrogate: replaced
        send_bytes('{8'hED, 8'hB0, 8'h80}, 1'b0);         // low surrogate: passes
        send_bytes('{8'hF0, 8'h9F, 8'h98, 8'h80}, 1'b0);  // above the BMP: replaced
        // Five-trailer lead with trailing bytes, not all of them 10xxxxxx
        send_bytes('{8'hFF, 8'h3F, 8'h00, 8'hFF, 8'h80, 8'hBF}, 1'b0);
        send_byte(8'h80, 1'b0);                           // stray continuation as lead
        send_bytes('{8'hE2, 8'h82}, 1'b1);                // string ends mid-sequence
        send_byte(8'h41, 1'b1);                           // single-byte string
        wait_drained();
    endtask

    task automatic test_random_text(input int n);
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        send_random_bytes(n);
        wait_drained();
    endtask

    // Hold the sink off long enough to fill the pipe and stall the input
    task automatic test_backpressure(input int n);
        src_idle_on = 1'b0;
        sink_hold_req = SINK_HOLD_CYCLES;
        repeat (n) send_byte(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
        send_random_bytes(n);
        src_idle_on = 1'b1;
        wait_drained();
    endtask

    // Back-to-back bytes and an always-ready sink
    task automatic test_steady_stream(input int n);
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        send_random_bytes(n);
        src_idle_on = 1'b1;
        sink_idle_on = 1'b1;
        wait_drained();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_text(600);
        test_backpressure(40);
        test_steady_stream(250);
        test_random_text(100);

        $display("covered %0d bytes and %0d results (%0d replaced, %0d truncated)",
                 bytes_sent, glyphs_checked, replaced_seen, truncated_seen);
        $display({"with random idling, a %0d-cycle sink hold and drained pauses;",
                  " %0d mismatches, %0d left over"},
                 SINK_HOLD_CYCLES, mismatch_count, pending_glyphs.size());
        if (mismatch_count == 0 && pending_glyphs.size() == 0) begin
            $display("status: pass");
        end
        else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/utc_pkg.sv
rtl/core/utc_accum.sv
rtl/core/utc_resolve.sv
rtl/core/utf8_to_cp437_glyph_decoder_top.sv
tb/tb_top.sv
